### hw/rtl/fsrl_pkg.sv
`timescale 1ns / 1ps

package fsrl_pkg;

  localparam int FRAME_W = 4;
  localparam int ROW_W   = 3;
  localparam int MOD_W   = 3;
  localparam int WORD_W  = 16;
  localparam int SHIFT_W = 4;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_LATCH = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HCAP,
    ST_EMIT
  } state_t;

  typedef struct packed {
    op_t                op;
    logic [FRAME_W-1:0] frame;
    logic [ROW_W-1:0]   row;
    logic [MOD_W-1:0]   module_idx;
    logic [WORD_W-1:0]  data;
    logic [MOD_W-1:0]   mo;
    logic [SHIFT_W-1:0] b;
  } cmd_t;

  typedef struct packed {
    logic [ROW_W-1:0]  row;
    logic [MOD_W-1:0]  module_idx;
    logic [WORD_W-1:0] word;
    logic              last;
  } res_t;

endpackage

### hw/rtl/fsrl_queue.sv
`timescale 1ns / 1ps

module fsrl_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);

  logic [W-1:0] slot_r [2];
  logic         wr_ptr_r;
  logic         wr_ptr_nxt;
  logic         rd_ptr_r;
  logic         rd_ptr_nxt;
  logic [1:0]   cnt_r;
  logic [1:0]   cnt_nxt;
  logic         do_push;
  logic         do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign rdata   = slot_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ do_push;
    rd_ptr_nxt = rd_ptr_r ^ do_pop;
    cnt_nxt    = cnt_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= wdata;
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("queue count out of range");
  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd1) |-> (wr_ptr_r != rd_ptr_r))
    else $error("queue pointers disagree with count");
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> (cnt_r == $past(cnt_r) + 2'd1))
    else $error("queue count did not follow push");
`endif

endmodule

### hw/rtl/fsrl_front.sv
`timescale 1ns / 1ps

module fsrl_front #(
  parameter int MODULES = 4,
  parameter int ROWS    = 8,
  parameter int FRAMES  = 4
) (
  input  logic                 in_push,
  output logic                 in_full,
  input  logic                 in_op,
  input  logic [7:0]           in_frame_index,
  input  logic [2:0]           in_row_index,
  input  logic [2:0]           in_module_index,
  input  logic [15:0]          in_data_word,
  input  logic [6:0]           in_offset_bits,
  input  logic                 clearing,
  input  logic                 cq_full,
  output logic                 cq_push,
  output fsrl_pkg::cmd_t       cq_cmd
);

  localparam int FR_RECIP = (1 << 16) / FRAMES + 1;
  localparam int MO_RECIP = (1 << 16) / MODULES + 1;

  logic       accept;
  logic       wr_ok;
  logic [7:0] frame_quo;
  logic [7:0] frame_back;
  logic [7:0] frame_mod;
  logic [2:0] mo_quo;
  logic [2:0] mo_back;
  logic [2:0] mo_mod;

  assign in_full = cq_full || clearing;
  assign accept  = in_push && !in_full;

  // remainders by the constant sizes through a scaled reciprocal
  assign frame_quo  = 8'((24'(in_frame_index) * 24'(FR_RECIP)) >> 16);
  assign frame_back = frame_quo * 8'(FRAMES);
  assign frame_mod  = in_frame_index - frame_back;

  assign mo_quo  = 3'((20'(in_offset_bits[6:4]) * 20'(MO_RECIP)) >> 16);
  assign mo_back = 3'({1'b0, mo_quo} * 4'(MODULES));
  assign mo_mod  = in_offset_bits[6:4] - mo_back;

  assign wr_ok = (in_frame_index < 8'(FRAMES)) &&
                 ({1'b0, in_row_index} < 4'(ROWS)) &&
                 ({1'b0, in_module_index} < 4'(MODULES));

  always_comb begin
    cq_cmd.op         = fsrl_pkg::op_t'(in_op);
    cq_cmd.row        = in_row_index;
    cq_cmd.module_idx = in_module_index;
    cq_cmd.data       = in_data_word;
    cq_cmd.mo         = mo_mod;
    cq_cmd.b          = in_offset_bits[3:0];
    if (cq_cmd.op == fsrl_pkg::OP_LATCH) begin
      cq_cmd.frame = frame_mod[fsrl_pkg::FRAME_W-1:0];
    end else begin
      cq_cmd.frame = in_frame_index[fsrl_pkg::FRAME_W-1:0];
    end
    // ignored writes are dropped here
    cq_push = accept && ((cq_cmd.op == fsrl_pkg::OP_LATCH) || wr_ok);
  end

endmodule

### hw/rtl/fsrl_back.sv
`timescale 1ns / 1ps

module fsrl_back #(
  parameter int MODULES = 4,
  parameter int ROWS    = 8,
  parameter int FRAMES  = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  output logic                 clearing,
  input  logic                 cq_empty,
  input  fsrl_pkg::cmd_t       cq_cmd,
  output logic                 cq_pop,
  input  logic                 oq_full,
  output logic                 oq_push,
  output fsrl_pkg::res_t       oq_res
);

  localparam int FW    = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int MW    = (MODULES > 1) ? $clog2(MODULES) : 1;
  localparam int AW    = FW + RW + MW;
  localparam int DEPTH = 1 << AW;

  localparam logic [fsrl_pkg::MOD_W-1:0] MOD_TOP = fsrl_pkg::MOD_W'(MODULES - 1);
  localparam logic [fsrl_pkg::ROW_W-1:0] ROW_TOP = fsrl_pkg::ROW_W'(ROWS - 1);

  logic [15:0] mem [DEPTH];
  logic [15:0] mem_q;
  logic        mem_we;
  logic [AW-1:0] mem_wa;
  logic [15:0] mem_wd;
  logic        mem_re;
  logic [AW-1:0] mem_ra;

  fsrl_pkg::state_t state_r, state_nxt;
  logic [AW-1:0]                  clr_addr_r, clr_addr_nxt;
  logic [fsrl_pkg::FRAME_W-1:0]   frame_r, frame_nxt;
  logic [fsrl_pkg::ROW_W-1:0]     row_r, row_nxt;
  logic [fsrl_pkg::MOD_W-1:0]     m_r, m_nxt;
  logic [fsrl_pkg::MOD_W-1:0]     idx_r, idx_nxt;
  logic [fsrl_pkg::MOD_W-1:0]     mo_r, mo_nxt;
  logic [fsrl_pkg::SHIFT_W-1:0]   b_r, b_nxt;
  logic [15:0]                    hi_r, hi_nxt;
  logic [31:0]                    pair;

  function automatic logic [fsrl_pkg::MOD_W-1:0] dec_wrap(
    input logic [fsrl_pkg::MOD_W-1:0] v
  );
    return (v == '0) ? MOD_TOP : v - 1'b1;
  endfunction

  assign clearing = (state_r == fsrl_pkg::ST_CLEAR);
  assign pair     = {hi_r, mem_q} >> b_r;

  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    frame_nxt    = frame_r;
    row_nxt      = row_r;
    m_nxt        = m_r;
    idx_nxt      = idx_r;
    mo_nxt       = mo_r;
    b_nxt        = b_r;
    hi_nxt       = hi_r;
    mem_we       = 1'b0;
    mem_wa       = clr_addr_r;
    mem_wd       = '0;
    mem_re       = 1'b0;
    mem_ra       = {frame_r[FW-1:0], row_r[RW-1:0], idx_r[MW-1:0]};
    cq_pop       = 1'b0;
    oq_push      = 1'b0;
    oq_res.row        = row_r;
    oq_res.module_idx = m_r;
    oq_res.word       = pair[15:0];
    oq_res.last       = (row_r == ROW_TOP) && (m_r == '0);

    unique case (state_r)
      fsrl_pkg::ST_CLEAR: begin
        mem_we       = 1'b1;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == AW'(DEPTH - 1)) begin
          state_nxt = fsrl_pkg::ST_IDLE;
        end
      end
      fsrl_pkg::ST_IDLE: begin
        if (!cq_empty) begin
          cq_pop = 1'b1;
          if (cq_cmd.op == fsrl_pkg::OP_WRITE) begin
            mem_we = 1'b1;
            mem_wa = {cq_cmd.frame[FW-1:0], cq_cmd.row[RW-1:0], cq_cmd.module_idx[MW-1:0]};
            mem_wd = cq_cmd.data;
          end else begin
            // upper neighbor of the last module sits at the module offset
            mem_re    = 1'b1;
            mem_ra    = {cq_cmd.frame[FW-1:0], {RW{1'b0}}, cq_cmd.mo[MW-1:0]};
            frame_nxt = cq_cmd.frame;
            mo_nxt    = cq_cmd.mo;
            b_nxt     = cq_cmd.b;
            row_nxt   = '0;
            m_nxt     = MOD_TOP;
            idx_nxt   = dec_wrap(cq_cmd.mo);
            state_nxt = fsrl_pkg::ST_HCAP;
          end
        end
      end
      fsrl_pkg::ST_HCAP: begin
        hi_nxt    = mem_q;
        mem_re    = 1'b1;
        state_nxt = fsrl_pkg::ST_EMIT;
      end
      fsrl_pkg::ST_EMIT: begin
        if (!oq_full) begin
          oq_push = 1'b1;
          hi_nxt  = mem_q;
          if (m_r == '0) begin
            if (row_r == ROW_TOP) begin
              state_nxt = fsrl_pkg::ST_IDLE;
            end else begin
              row_nxt   = row_r + 1'b1;
              m_nxt     = MOD_TOP;
              idx_nxt   = dec_wrap(mo_r);
              mem_re    = 1'b1;
              mem_ra    = {frame_r[FW-1:0], row_nxt[RW-1:0], mo_r[MW-1:0]};
              state_nxt = fsrl_pkg::ST_HCAP;
            end
          end else begin
            m_nxt   = m_r - 1'b1;
            idx_nxt = dec_wrap(idx_r);
            mem_re  = 1'b1;
            mem_ra  = {frame_r[FW-1:0], row_r[RW-1:0], idx_nxt[MW-1:0]};
          end
        end
      end
      default: begin
        state_nxt = fsrl_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= fsrl_pkg::ST_CLEAR;
      clr_addr_r <= '0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    frame_r <= frame_nxt;
    row_r   <= row_nxt;
    m_r     <= m_nxt;
    idx_r   <= idx_nxt;
    mo_r    <= mo_nxt;
    b_r     <= b_nxt;
    hi_r    <= hi_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      mem_q <= mem[mem_ra];
    end
  end

`ifndef NO_ASSERTIONS
  a_no_pop_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !cq_pop)
    else $error("command taken during clearing pass");
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    oq_push |-> !oq_full)
    else $error("result pushed into full queue");
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (oq_push && oq_res.last) |=> (state_r == fsrl_pkg::ST_IDLE))
    else $error("latch did not end on final word");
  a_no_mem_conflict: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_we && mem_re))
    else $error("store read and written together");
`endif

endmodule

### hw/rtl/frame_store_rotating_latch_core.sv
`timescale 1ns / 1ps

// Frame store for a chain of LED matrix modules: FRAMES frames of ROWS rows of
// MODULES 16-bit words. A write transaction stores one word (out-of-range writes are
// dropped at the front); a latch transaction streams the frame rotated across the
// concatenated row, ROWS*MODULES result words, row 0 first, module MODULES-1 down to 0,
// the final word flagged by out_last. The store has a single read port: a latch
// occupies the back end until its final word is pushed to the result queue, a write
// while popped; a two-entry command queue and a two-entry result queue let the input
// and output sides stall independently. After reset a clearing pass zeroes the store
// at one address per cycle, 2**(frame bits + row bits + module bits) addresses with
// each index at least one bit wide (128 at the defaults), with in_full held high.
module frame_store_rotating_latch_core #(
  parameter int MODULES = 4,
  parameter int ROWS    = 8,
  parameter int FRAMES  = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic        in_op,
  input  logic [7:0]  in_frame_index,
  input  logic [2:0]  in_row_index,
  input  logic [2:0]  in_module_index,
  input  logic [15:0] in_data_word,
  input  logic [6:0]  in_offset_bits,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [2:0]  out_row,
  output logic [2:0]  out_module,
  output logic [15:0] out_word,
  output logic        out_last
);

  localparam int CMD_W = $bits(fsrl_pkg::cmd_t);
  localparam int RES_W = $bits(fsrl_pkg::res_t);

  logic                 clearing;
  logic                 cq_push;
  logic                 cq_full;
  logic                 cq_pop;
  logic                 cq_empty;
  fsrl_pkg::cmd_t       cq_in;
  fsrl_pkg::cmd_t       cq_out;
  logic                 oq_push;
  logic                 oq_full;
  fsrl_pkg::res_t       oq_in;
  fsrl_pkg::res_t       oq_out;

  fsrl_front #(
    .MODULES (MODULES),
    .ROWS    (ROWS),
    .FRAMES  (FRAMES)
  ) u_front (
    .in_push         (in_push),
    .in_full         (in_full),
    .in_op           (in_op),
    .in_frame_index  (in_frame_index),
    .in_row_index    (in_row_index),
    .in_module_index (in_module_index),
    .in_data_word    (in_data_word),
    .in_offset_bits  (in_offset_bits),
    .clearing        (clearing),
    .cq_full         (cq_full),
    .cq_push         (cq_push),
    .cq_cmd          (cq_in)
  );

  fsrl_queue #(
    .W (CMD_W)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cq_push),
    .wdata (cq_in),
    .full  (cq_full),
    .pop   (cq_pop),
    .rdata (cq_out),
    .empty (cq_empty)
  );

  fsrl_back #(
    .MODULES (MODULES),
    .ROWS    (ROWS),
    .FRAMES  (FRAMES)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .clearing (clearing),
    .cq_empty (cq_empty),
    .cq_cmd   (cq_out),
    .cq_pop   (cq_pop),
    .oq_full  (oq_full),
    .oq_push  (oq_push),
    .oq_res   (oq_in)
  );

  fsrl_queue #(
    .W (RES_W)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (oq_push),
    .wdata (oq_in),
    .full  (oq_full),
    .pop   (out_pop),
    .rdata (oq_out),
    .empty (out_empty)
  );

  assign out_row    = oq_out.row;
  assign out_module = oq_out.module_idx;
  assign out_word   = oq_out.word;
  assign out_last   = oq_out.last;

endmodule

### bench/frame_store_rotating_latch_core_tb.sv
`timescale 1ns / 1ps

module frame_store_rotating_latch_core_tb;

  localparam int MODULES    = 4;
  localparam int ROWS       = 8;
  localparam int FRAMES     = 4;
  localparam int ROW_BITS   = MODULES * 16;
  localparam int STALL_MAX  = 2000;
  localparam int DRAIN_WAIT = 100;
  localparam int RANDOM_ITEMS = 400;

  typedef struct {
    fsrl_pkg::op_t op;
    logic [7:0]    frame;
    logic [2:0]    row;
    logic [2:0]    module_idx;
    logic [15:0]   data;
    logic [6:0]    offset;
  } frame_item_t;

  logic        clk;
  logic        rst_n;
  logic        in_push;
  logic        in_full;
  logic        in_op;
  logic [7:0]  in_frame_index;
  logic [2:0]  in_row_index;
  logic [2:0]  in_module_index;
  logic [15:0] in_data_word;
  logic [6:0]  in_offset_bits;
  logic        out_empty;
  logic        out_pop;
  logic [2:0]  out_row;
  logic [2:0]  out_module;
  logic [15:0] out_word;
  logic        out_last;

  frame_item_t    pending_items[$];
  fsrl_pkg::res_t rotated_words_due[$];
  logic [15:0]    shadow_store [FRAMES][ROWS][MODULES];

  int  mismatches;
  int  idle_cycles;
  int  in_gap;
  int  out_gap;
  int  gap_pick;
  bit  in_taken;
  bit  out_taken;
  bit  in_quiet;
  bit  out_quiet;
  frame_item_t next_item;

  frame_store_rotating_latch_core #(
    .MODULES(MODULES),
    .ROWS   (ROWS),
    .FRAMES (FRAMES)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_op          (in_op),
    .in_frame_index (in_frame_index),
    .in_row_index   (in_row_index),
    .in_module_index(in_module_index),
    .in_data_word   (in_data_word),
    .in_offset_bits (in_offset_bits),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_row        (out_row),
    .out_module     (out_module),
    .out_word       (out_word),
    .out_last       (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap(input bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 50) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  task automatic flag_mismatch(input string what, input int got, input int want);
    $display("mismatch on %s: got 0x%0h, want 0x%0h", what, got, want);
    mismatches++;
  endtask

  // write updates the shadow store, latch queues the rotated row words
  task automatic apply_frame_item(input frame_item_t it);
    int   fr;
    int   off;
    int   mo;
    int   b;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] w;
    fsrl_pkg::res_t res;
    if (it.op == fsrl_pkg::OP_WRITE) begin
      if (it.frame < FRAMES && it.row < ROWS && it.module_idx < MODULES) begin
        shadow_store[it.frame][it.row][it.module_idx] = it.data;
      end
    end else begin
      fr  = it.frame % FRAMES;
      off = it.offset % ROW_BITS;
      mo  = off / 16;
      b   = off % 16;
      for (int r = 0; r < ROWS; r++) begin
        for (int m = MODULES - 1; m >= 0; m--) begin
          lo = {16'h0, shadow_store[fr][r][(m + mo) % MODULES]};
          hi = {16'h0, shadow_store[fr][r][(m + 1 + mo) % MODULES]};
          w  = (lo >> b) | (hi << (16 - b));
          res.row        = r[2:0];
          res.module_idx = m[2:0];
          res.word       = w[15:0];
          res.last       = (r == ROWS - 1) && (m == 0);
          rotated_words_due.push_back(res);
        end
      end
    end
  endtask

  task automatic queue_item(input fsrl_pkg::op_t op, input int fr, input int row,
                            input int mod, input int data, input int off);
    frame_item_t it;
    it.op         = op;
    it.frame      = fr[7:0];
    it.row        = row[2:0];
    it.module_idx = mod[2:0];
    it.data       = data[15:0];
    it.offset     = off[6:0];
    pending_items.push_back(it);
  endtask

  // input side
  always @(negedge clk) begin
    if (rst_n && (!in_push || in_taken)) begin
      if (in_gap > 0) begin
        in_push <= 1'b0;
        in_gap  <= in_gap - 1;
      end else if (pending_items.size() != 0) begin
        next_item       = pending_items.pop_front();
        in_op           <= next_item.op;
        in_frame_index  <= next_item.frame;
        in_row_index    <= next_item.row;
        in_module_index <= next_item.module_idx;
        in_data_word    <= next_item.data;
        in_offset_bits  <= next_item.offset;
        in_push         <= 1'b1;
        in_gap          <= pick_gap(in_quiet);
        if ($urandom_range(0, 49) == 0) begin
          in_quiet <= !in_quiet;
        end
      end else begin
        in_push <= 1'b0;
      end
    end
  end

  // result side
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_gap > 0) begin
        out_pop <= 1'b0;
        out_gap <= out_gap - 1;
      end else if (out_pop && out_taken) begin
        gap_pick = pick_gap(out_quiet);
        out_pop <= (gap_pick == 0);
        out_gap <= (gap_pick == 0) ? 0 : gap_pick - 1;
        if ($urandom_range(0, 99) == 0) begin
          out_quiet <= !out_quiet;
        end
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    frame_item_t seen;
    fsrl_pkg::res_t want;
    in_taken  <= rst_n && in_push && !in_full;
    out_taken <= rst_n && out_pop && !out_empty;
    if (rst_n && in_push && !in_full) begin
      seen.op         = fsrl_pkg::op_t'(in_op);
      seen.frame      = in_frame_index;
      seen.row        = in_row_index;
      seen.module_idx = in_module_index;
      seen.data       = in_data_word;
      seen.offset     = in_offset_bits;
      apply_frame_item(seen);
    end
    if (rst_n && out_pop && !out_empty) begin
      if (rotated_words_due.size() == 0) begin
        flag_mismatch("result transaction with nothing pending", out_word, 0);
      end else begin
        want = rotated_words_due.pop_front();
        if (out_row !== want.row) begin
          flag_mismatch("out_row", out_row, want.row);
        end
        if (out_module !== want.module_idx) begin
          flag_mismatch("out_module", out_module, want.module_idx);
        end
        if (out_word !== want.word) begin
          flag_mismatch("out_word", out_word, want.word);
        end
        if (out_last !== want.last) begin
          flag_mismatch("out_last", out_last, want.last);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_push && !in_full) || (out_pop && !out_empty)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_MAX) begin
        $display("FAIL frame_store_rotating_latch_core");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int counted;
    int r;
    rst_n           = 1'b0;
    in_push         = 1'b0;
    in_op           = fsrl_pkg::OP_WRITE;
    in_frame_index  = '0;
    in_row_index    = '0;
    in_module_index = '0;
    in_data_word    = '0;
    in_offset_bits  = '0;
    out_pop         = 1'b0;
    mismatches      = 0;
    idle_cycles     = 0;
    in_gap          = 0;
    out_gap         = 0;
    in_taken        = 1'b0;
    out_taken       = 1'b0;
    in_quiet        = 1'b0;
    out_quiet       = 1'b0;
    for (int f = 0; f < FRAMES; f++) begin
      for (int rw = 0; rw < ROWS; rw++) begin
        for (int m = 0; m < MODULES; m++) begin
          shadow_store[f][rw][m] = '0;
        end
      end
    end

    // directed
    queue_item(fsrl_pkg::OP_LATCH, 0, 0, 0, 0, 0);
    queue_item(fsrl_pkg::OP_WRITE, 0, 0, 0, 16'hffff, 127);
    queue_item(fsrl_pkg::OP_WRITE, 3, 7, 3, 16'h8001, 0);
    queue_item(fsrl_pkg::OP_WRITE, 3, 7, 0, 16'h1234, 0);
    queue_item(fsrl_pkg::OP_WRITE, 3, 7, 1, 16'hf00f, 0);
    queue_item(fsrl_pkg::OP_WRITE, 3, 7, 2, 16'h0ff0, 0);
    queue_item(fsrl_pkg::OP_WRITE, 4, 1, 1, 16'hdead, 0);
    queue_item(fsrl_pkg::OP_WRITE, 255, 2, 2, 16'hbeef, 0);
    queue_item(fsrl_pkg::OP_WRITE, 1, 3, 4, 16'hcafe, 0);
    queue_item(fsrl_pkg::OP_WRITE, 2, 5, 7, 16'h5555, 0);
    queue_item(fsrl_pkg::OP_WRITE, 0, 7, 3, 16'h0001, 0);
    queue_item(fsrl_pkg::OP_LATCH, 3, 0, 0, 0, 0);
    queue_item(fsrl_pkg::OP_LATCH, 255, 7, 7, 16'hffff, 127);
    queue_item(fsrl_pkg::OP_LATCH, 4, 5, 6, 16'h1111, 64);
    queue_item(fsrl_pkg::OP_LATCH, 3, 0, 0, 0, 16);
    queue_item(fsrl_pkg::OP_LATCH, 7, 0, 0, 0, 1);
    queue_item(fsrl_pkg::OP_LATCH, 3, 0, 0, 0, 15);
    queue_item(fsrl_pkg::OP_LATCH, 0, 0, 0, 0, 63);
    queue_item(fsrl_pkg::OP_LATCH, 128, 0, 0, 0, 79);
    queue_item(fsrl_pkg::OP_LATCH, 1, 0, 0, 0, 0);
    queue_item(fsrl_pkg::OP_LATCH, 2, 0, 0, 0, 48);

    // random, mostly in-range writes with regular latches
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 12) begin
        queue_item(fsrl_pkg::OP_LATCH, $urandom_range(0, 255), $urandom_range(0, 7),
                   $urandom_range(0, 7), $urandom_range(0, 65535), $urandom_range(0, 127));
        counted++;
      end else if (r < 88) begin
        queue_item(fsrl_pkg::OP_WRITE, $urandom_range(0, FRAMES - 1),
                   $urandom_range(0, ROWS - 1), $urandom_range(0, MODULES - 1),
                   $urandom_range(0, 65535), $urandom_range(0, 127));
        counted++;
      end else begin
        queue_item(fsrl_pkg::OP_WRITE, $urandom_range(0, 255), $urandom_range(0, 7),
                   $urandom_range(0, 7), $urandom_range(0, 65535), $urandom_range(0, 127));
        counted++;
      end
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_items.size() != 0 || in_push) begin
      @(posedge clk);
    end
    while (rotated_words_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_WAIT) @(posedge clk);

    if (mismatches == 0) begin
      $display("PASS frame_store_rotating_latch_core");
    end else begin
      $display("FAIL frame_store_rotating_latch_core");
    end
    $finish;
  end

endmodule
